### design/lzd_pkg.sv
package lzd_pkg;

  localparam int TableBitsDef    = 16;
  localparam int MaxStringLenDef = 64;

  localparam int EntryW   = 25;
  localparam int PosW     = 16;
  localparam int SymW     = 8;
  localparam int ProbeW   = 8;

  localparam logic [ProbeW-1:0] MaxProbesRst = 8'd3;
  localparam int FirstStep = 3;
  localparam int NextStep  = 4;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusProbe = 2'd1;
  localparam logic [1:0] StatusTrunc = 2'd2;

  typedef struct packed {
    logic [PosW-1:0] prefix_position;
    logic [SymW-1:0] new_symbol;
  } in_item_t;

  typedef struct packed {
    logic [SymW-1:0] out_byte;
    logic            last_byte;
    logic [1:0]      status;
  } out_item_t;

  typedef struct packed {
    logic            valid;
    logic [PosW-1:0] link;
    logic [SymW-1:0] symbol;
  } dict_entry_t;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StProbe,
    StWalk,
    StPop,
    StErr
  } state_e;

endpackage

### design/lz78_hashed_dictionary_decoder.sv
// Output: once a pair is taken and its string is stacked, the words leave one per
//   cycle unless stalled.
// Pairs: one pair at a time; a rejected pair gives its single word.
// Reset: after rst_ni releases, a clear sweep writes all 2**TABLE_BITS dictionary
//   words, one per cycle, before the first pair is accepted; config writes are taken.
module lz78_hashed_dictionary_decoder #(
  parameter int TABLE_BITS     = lzd_pkg::TableBitsDef,
  parameter int MAX_STRING_LEN = lzd_pkg::MaxStringLenDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lzd_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lzd_pkg::out_item_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i
);

  localparam int Tb    = TABLE_BITS;
  localparam int Hw    = (TABLE_BITS > lzd_pkg::PosW) ? TABLE_BITS : lzd_pkg::PosW;
  localparam int StkAw = $clog2(MAX_STRING_LEN);
  localparam int CntW  = $clog2(MAX_STRING_LEN + 1);

  lzd_pkg::state_e state_q, state_d;

  logic [lzd_pkg::PosW-1:0]   pos_q, pos_d;
  logic [lzd_pkg::SymW-1:0]   sym_q, sym_d;
  logic [Tb-1:0]              slot_q, slot_d;
  logic [lzd_pkg::ProbeW-1:0] probes_q, probes_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [1:0]                 status_q, status_d;
  logic [Tb-1:0]              clr_q, clr_d;
  logic [7:0]                 max_probes_q;

  logic                     out_valid_q;
  lzd_pkg::out_item_t       out_q, out_d;
  logic                     out_load;
  logic                     out_free;

  logic                     d_we, d_re;
  logic [Tb-1:0]            d_waddr, d_raddr;
  logic [lzd_pkg::EntryW-1:0] d_wdata, d_rdata;
  lzd_pkg::dict_entry_t     ent;

  logic                     s_we, s_re;
  logic [StkAw-1:0]         s_waddr, s_raddr;
  logic [lzd_pkg::SymW-1:0] s_wdata, s_rdata;

  logic [Hw-1:0]            hash_w, pos_w, link_w;
  logic [Tb-1:0]            hash_idx, pos_idx, link_idx, slot_nxt;
  logic [CntW-1:0]          cnt_inc;
  logic                     is_match;

  lzd_ram #(
    .W (lzd_pkg::EntryW),
    .D (1 << TABLE_BITS)
  ) u_dict (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (d_waddr),
    .wdata_i (d_wdata),
    .re_i    (d_re),
    .raddr_i (d_raddr),
    .rdata_o (d_rdata)
  );

  lzd_ram #(
    .W (lzd_pkg::SymW),
    .D (MAX_STRING_LEN)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  assign ent      = lzd_pkg::dict_entry_t'(d_rdata);
  assign hash_w   = Hw'(in_data_i.prefix_position ^ {in_data_i.new_symbol, 8'h00});
  assign pos_w    = Hw'(pos_q);
  assign link_w   = Hw'(ent.link);
  assign hash_idx = hash_w[Tb-1:0];
  assign pos_idx  = pos_w[Tb-1:0];
  assign link_idx = link_w[Tb-1:0];
  assign slot_nxt = slot_q + ((probes_q == '0) ? Tb'(lzd_pkg::FirstStep)
                                               : Tb'(lzd_pkg::NextStep));
  assign cnt_inc  = cnt_q + CntW'(1);
  assign is_match = (ent.symbol == sym_q) && (ent.link == pos_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    sym_d      = sym_q;
    slot_d     = slot_q;
    probes_d   = probes_q;
    cnt_d      = cnt_q;
    status_d   = status_q;
    clr_d      = clr_q;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    out_d      = out_q;
    d_we       = 1'b0;
    d_waddr    = slot_q;
    d_wdata    = {1'b1, pos_q, sym_q};
    d_re       = 1'b0;
    d_raddr    = slot_q;
    s_we       = 1'b0;
    s_waddr    = cnt_q[StkAw-1:0];
    s_wdata    = sym_q;
    s_re       = 1'b0;
    s_raddr    = cnt_q[StkAw-1:0];

    case (state_q)
      lzd_pkg::StClear: begin
        d_we    = 1'b1;
        d_waddr = clr_q;
        d_wdata = '0;
        clr_d   = clr_q + Tb'(1);
        if (clr_q == {Tb{1'b1}}) begin
          state_d = lzd_pkg::StIdle;
        end
      end

      lzd_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          pos_d    = in_data_i.prefix_position;
          sym_d    = in_data_i.new_symbol;
          slot_d   = hash_idx;
          probes_d = '0;
          status_d = lzd_pkg::StatusOk;
          d_re     = 1'b1;
          d_raddr  = hash_idx;
          state_d  = lzd_pkg::StProbe;
        end
      end

      lzd_pkg::StProbe: begin
        if (!ent.valid || is_match) begin
          // found or inserted: the entry is (pos, sym), push sym without a read
          d_we    = !ent.valid;
          s_we    = 1'b1;
          s_waddr = '0;
          s_wdata = sym_q;
          if (pos_q == '0) begin
            cnt_d   = '0;
            s_re    = 1'b1;
            s_raddr = '0;
            state_d = lzd_pkg::StPop;
          end else begin
            cnt_d   = CntW'(1);
            d_re    = 1'b1;
            d_raddr = pos_idx;
            state_d = lzd_pkg::StWalk;
          end
        end else if (probes_q >= max_probes_q) begin
          state_d = lzd_pkg::StErr;
        end else begin
          slot_d   = slot_nxt;
          probes_d = probes_q + lzd_pkg::ProbeW'(1);
          d_re     = 1'b1;
          d_raddr  = slot_nxt;
        end
      end

      lzd_pkg::StWalk: begin
        s_we    = 1'b1;
        s_wdata = ent.symbol;
        if (ent.link == '0) begin
          s_re    = 1'b1;
          state_d = lzd_pkg::StPop;
        end else if (cnt_inc >= CntW'(MAX_STRING_LEN)) begin
          status_d = lzd_pkg::StatusTrunc;
          s_re     = 1'b1;
          state_d  = lzd_pkg::StPop;
        end else begin
          cnt_d   = cnt_inc;
          d_re    = 1'b1;
          d_raddr = link_idx;
        end
      end

      lzd_pkg::StPop: begin
        // cnt_q is the stack index whose symbol sits in s_rdata
        if (out_free) begin
          out_load        = 1'b1;
          out_d.out_byte  = s_rdata;
          out_d.last_byte = (cnt_q == '0);
          out_d.status    = status_q;
          if (cnt_q == '0) begin
            state_d = lzd_pkg::StIdle;
          end else begin
            cnt_d   = cnt_q - CntW'(1);
            s_re    = 1'b1;
            s_raddr = cnt_d[StkAw-1:0];
          end
        end
      end

      lzd_pkg::StErr: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_d.out_byte  = '0;
          out_d.last_byte = 1'b1;
          out_d.status    = lzd_pkg::StatusProbe;
          state_d         = lzd_pkg::StIdle;
        end
      end

      default: begin
        state_d = lzd_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lzd_pkg::StClear;
      clr_q        <= '0;
      probes_q     <= '0;
      cnt_q        <= '0;
      status_q     <= lzd_pkg::StatusOk;
      out_valid_q  <= 1'b0;
      max_probes_q <= lzd_pkg::MaxProbesRst;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      probes_q <= probes_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        max_probes_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    sym_q  <= sym_d;
    slot_q <= slot_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### design/lzd_ram.sv
module lzd_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic                 re_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // write-first: a read of the word being written returns the new word
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/lzd_chk.sv
module lzd_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input lzd_pkg::out_item_t out_data_o
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // one pair at a time
  a_one_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a pair is in flight");

  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == lzd_pkg::StatusProbe) |->
      out_data_o.last_byte && (out_data_o.out_byte == '0))
    else $error("probe-limit word malformed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == lzd_pkg::StatusOk) ||
                    (out_data_o.status == lzd_pkg::StatusProbe) ||
                    (out_data_o.status == lzd_pkg::StatusTrunc))
    else $error("undefined status code");

endmodule

bind lz78_hashed_dictionary_decoder lzd_chk u_lzd_chk (.*);
